>>> hdl/annexb_pkg.sv
// Shared types and constants for the Annex B NAL unit splitter.
package annexb_pkg;

  localparam int HOLD_DEPTH = 4;
  localparam int LANES      = HOLD_DEPTH + 1;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_ONE   = 8'h01;
  localparam logic [4:0] TYPE_DELIM = 5'h09;

  // One burst of payload bytes released by a single input byte.
  typedef struct packed {
    logic [LANES-1:0][7:0] bytes;
    logic [2:0]            cnt;
    logic [4:0]            ntype;
    logic                  first;
    logic                  last;
  } desc_t;

endpackage

>>> hdl/annexb_front.sv
// Front end: start code scan, byte holding and burst descriptor generation.
module annexb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               fire,
  input  logic [7:0]         in_byte,
  input  logic               in_end_of_stream,
  output logic               push,
  output annexb_pkg::desc_t  push_data
);
  import annexb_pkg::*;

  logic [7:0] held_r [HOLD_DEPTH];
  logic [7:0] held_nxt [HOLD_DEPTH];
  logic [2:0] hc_r, hc_nxt;
  logic [1:0] zr_r, zr_nxt;
  logic       inside_r, inside_nxt;
  logic [4:0] type_r, type_nxt;
  logic       drop_r, drop_nxt;
  logic       aw_r, aw_nxt;
  logic       drop_cfg_r;

  logic       is_sc;
  logic [1:0] zr_inc;
  logic [2:0] used;
  logic [2:0] emit_cnt;
  logic       emit_last;
  logic [4:0] emit_type;
  logic       emit_drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_cfg_r <= 1'b1;
    end else if (cfg_we) begin
      drop_cfg_r <= cfg_wdata;
    end
  end

  assign is_sc  = (in_byte == BYTE_ONE) && (zr_r >= 2'd2);
  assign zr_inc = (zr_r == 2'd3) ? zr_r : zr_r + 2'd1;
  assign used   = (zr_r == 2'd3) ? 3'd3 : 3'd2;

  always_comb begin
    held_nxt   = held_r;
    hc_nxt     = hc_r;
    zr_nxt     = zr_r;
    inside_nxt = inside_r;
    type_nxt   = type_r;
    drop_nxt   = drop_r;
    aw_nxt     = aw_r;
    emit_cnt   = 3'd0;
    emit_last  = 1'b0;
    emit_type  = type_r;
    emit_drop  = drop_r;

    if (!inside_r) begin
      if (in_byte == BYTE_ZERO) begin
        zr_nxt = zr_inc;
      end else if (is_sc) begin
        inside_nxt = 1'b1;
        hc_nxt     = 3'd0;
        zr_nxt     = 2'd0;
        aw_nxt     = 1'b1;
        drop_nxt   = 1'b0;
      end else begin
        zr_nxt = 2'd0;
      end
    end else if (is_sc) begin
      // Bytes ahead of the start code zeros close the current unit.
      emit_cnt   = (hc_r > used) ? hc_r - used : 3'd0;
      emit_last  = 1'b1;
      inside_nxt = 1'b1;
      hc_nxt     = 3'd0;
      zr_nxt     = 2'd0;
      aw_nxt     = 1'b1;
      drop_nxt   = 1'b0;
    end else begin
      if (aw_r && hc_r == 3'd0) begin
        type_nxt = in_byte[4:0];
        drop_nxt = drop_cfg_r && (in_byte[4:0] == TYPE_DELIM);
      end
      emit_type = type_nxt;
      emit_drop = drop_nxt;
      if (in_byte == BYTE_ZERO) begin
        zr_nxt = zr_inc;
        if (hc_r == 3'(HOLD_DEPTH)) begin
          // Hold line full: the oldest byte leaves as ordinary payload.
          emit_cnt = 3'd1;
          for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
            held_nxt[i] = held_r[i+1];
          end
          held_nxt[HOLD_DEPTH-1] = in_byte;
        end else begin
          held_nxt[hc_r[1:0]] = in_byte;
          hc_nxt = hc_r + 3'd1;
        end
      end else begin
        emit_cnt    = hc_r;
        held_nxt[0] = in_byte;
        hc_nxt      = 3'd1;
        zr_nxt      = 2'd0;
      end
      if (in_end_of_stream) begin
        // Flush everything held plus this byte.
        emit_cnt  = hc_r + 3'd1;
        emit_last = 1'b1;
      end
    end

    if (emit_cnt != 3'd0 && !(inside_r && is_sc)) begin
      aw_nxt = 1'b0;
    end

    if (in_end_of_stream) begin
      hc_nxt     = 3'd0;
      zr_nxt     = 2'd0;
      inside_nxt = 1'b0;
      type_nxt   = 5'd0;
      drop_nxt   = 1'b0;
      aw_nxt     = 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      push_data.bytes[i] = (3'(i) < hc_r) ? held_r[i] : in_byte;
    end
    push_data.bytes[LANES-1] = in_byte;
    push_data.cnt   = emit_cnt;
    push_data.ntype = emit_type;
    push_data.first = aw_r;
    push_data.last  = emit_last;
  end

  assign push = fire && (emit_cnt != 3'd0) && !emit_drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r     <= 3'd0;
      zr_r     <= 2'd0;
      inside_r <= 1'b0;
      type_r   <= 5'd0;
      drop_r   <= 1'b0;
      aw_r     <= 1'b1;
    end else if (fire) begin
      hc_r     <= hc_nxt;
      zr_r     <= zr_nxt;
      inside_r <= inside_nxt;
      type_r   <= type_nxt;
      drop_r   <= drop_nxt;
      aw_r     <= aw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held_r <= held_nxt;
    end
  end

endmodule

>>> hdl/annexb_queue.sv
// Small descriptor queue between the front end and the byte serializer.
module annexb_queue #(
  parameter int DEPTH = annexb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  annexb_pkg::desc_t  push_data,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output annexb_pkg::desc_t  head_data
);
  import annexb_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> hdl/annexb_back.sv
// Back end: walks each descriptor and drives one payload byte per transfer.
module annexb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  annexb_pkg::desc_t  head_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic [4:0]         out_nal_type,
  output logic               out_first_of_nal,
  output logic               out_last_of_nal
);
  import annexb_pkg::*;

  logic [2:0] idx_r;
  logic       out_valid_r;
  logic [7:0] byte_r;
  logic [4:0] type_r;
  logic       first_r, last_r;
  logic       load;
  logic       final_lane;

  assign load       = head_valid && (!out_valid_r || out_ready);
  assign final_lane = (idx_r == head_data.cnt - 3'd1);
  assign pop        = load && final_lane;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r <= final_lane ? 3'd0 : idx_r + 3'd1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= head_data.bytes[idx_r];
      type_r  <= head_data.ntype;
      first_r <= head_data.first && (idx_r == 3'd0);
      last_r  <= head_data.last && final_lane;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = byte_r;
  assign out_nal_type     = type_r;
  assign out_first_of_nal = first_r;
  assign out_last_of_nal  = last_r;

endmodule

>>> hdl/annexb_nal_unit_splitter_unit.sv
// Top level of the Annex B NAL unit splitter.
//
//   Channel  Handshake               Payload
//   in       in_valid / in_ready     in_byte, in_end_of_stream
//   out      out_valid / out_ready   out_byte, out_nal_type, out_first_of_nal,
//                                    out_last_of_nal
//   cfg      cfg_we                  cfg_wdata (drop delimiter units)
//
// One input byte is taken per cycle while the descriptor queue has room; the
// output gives one payload byte per cycle, so the output port sets the rate.
// A byte that closes a unit or ends the stream can release up to five bytes,
// which the queue absorbs while input keeps flowing.
// Released bytes pass through the queue memory, then the output register.
// Reset is synchronous; the queue and output register come up empty.
module annexb_nal_unit_splitter_unit #(
  parameter int QUEUE_DEPTH = annexb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_stream,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [4:0] out_nal_type,
  output logic       out_first_of_nal,
  output logic       out_last_of_nal
);
  import annexb_pkg::*;

  logic  fire;
  logic  push, pop, full, head_valid;
  desc_t push_data, head_data;

  assign in_ready = !full;
  assign fire     = in_valid && in_ready;

  annexb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .fire             (fire),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .push             (push),
    .push_data        (push_data)
  );

  annexb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  annexb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_data        (head_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_nal_type     (out_nal_type),
    .out_first_of_nal (out_first_of_nal),
    .out_last_of_nal  (out_last_of_nal)
  );

endmodule

>>> tb/annexb_nal_unit_splitter_unit_tb.sv
// Self-checking testbench for the Annex B NAL unit splitter: a stimulus table, then random streams.
module annexb_nal_unit_splitter_unit_tb;
  import annexb_pkg::*;

  localparam logic [4:0] TYPE_SLICE = 5'd1;
  localparam logic [4:0] TYPE_IDR   = 5'd5;
  localparam logic [4:0] TYPE_SEI   = 5'd6;
  localparam logic [4:0] TYPE_SPS   = 5'd7;
  localparam logic [4:0] TYPE_PPS   = 5'd8;
  localparam logic [7:0] EMU_PREVENT = 8'h03;
  localparam int PHASES    = 6;
  localparam int PHASE_LEN = 50;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [7:0] data;
    logic [4:0] ntype;
    logic       first;
    logic       last;
  } payload_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } stream_byte_t;

  // cnt is the number of payload bytes the stream byte releases; want is typed
  // in only where chk is set.
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic [2:0] cnt;
    logic       chk;
    payload_t   want;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{8'hFF, 1'b0, 3'd0, 1'b0, 15'h0000},  // junk ahead of the first start code
    '{8'h00, 1'b0, 3'd0, 1'b0, 15'h0000},
    '{8'h00, 1'b0, 3'd0, 1'b0, 15'h0000},
    '{8'h01, 1'b0, 3'd0, 1'b0, 15'h0000},  // three-byte start code
    '{8'hE7, 1'b0, 3'd0, 1'b0, 15'h0000},  // SPS header is held
    '{8'h80, 1'b0, 3'd1, 1'b1, '{8'hE7, 5'd7, 1'b1, 1'b0}},
    '{8'h00, 1'b0, 3'd0, 1'b0, 15'h0000},
    '{8'h00, 1'b0, 3'd0, 1'b0, 15'h0000},
    '{8'h00, 1'b0, 3'd0, 1'b0, 15'h0000},
    '{8'h01, 1'b0, 3'd1, 1'b1, '{8'h80, 5'd7, 1'b0, 1'b1}},  // four-byte start code
    '{8'h09, 1'b0, 3'd0, 1'b0, 15'h0000},  // delimiter unit, dropped
    '{8'hF0, 1'b0, 3'd0, 1'b0, 15'h0000},
    '{8'h00, 1'b0, 3'd0, 1'b0, 15'h0000},
    '{8'h00, 1'b0, 3'd0, 1'b0, 15'h0000},
    '{8'h01, 1'b0, 3'd0, 1'b0, 15'h0000},
    '{8'h00, 1'b0, 3'd0, 1'b0, 15'h0000},  // type 0 unit made of zeros
    '{8'h00, 1'b0, 3'd0, 1'b0, 15'h0000},
    '{8'h00, 1'b0, 3'd0, 1'b0, 15'h0000},
    '{8'h00, 1'b0, 3'd0, 1'b0, 15'h0000},
    '{8'h00, 1'b0, 3'd1, 1'b1, '{8'h00, 5'd0, 1'b1, 1'b0}},  // long zero run spills
    '{8'h01, 1'b0, 3'd1, 1'b1, '{8'h00, 5'd0, 1'b0, 1'b1}},
    '{8'h00, 1'b0, 3'd0, 1'b0, 15'h0000},
    '{8'h00, 1'b0, 3'd0, 1'b0, 15'h0000},
    '{8'h01, 1'b0, 3'd0, 1'b0, 15'h0000},  // back-to-back start codes, empty unit
    '{8'hFF, 1'b1, 3'd1, 1'b1, '{8'hFF, 5'd31, 1'b1, 1'b1}}   // one-byte unit at stream end
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_stream = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [4:0] out_nal_type;
  logic       out_first_of_nal;
  logic       out_last_of_nal;

  annexb_nal_unit_splitter_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_nal_type     (out_nal_type),
    .out_first_of_nal (out_first_of_nal),
    .out_last_of_nal  (out_last_of_nal)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Parser shadow state.
  bit         drop_aud = 1'b1;
  logic [7:0] held_q[$];
  int         zrun;
  bit         in_unit;
  logic [4:0] unit_type;
  bit         unit_dropped;
  bit         want_first;
  int         released_now;
  payload_t   pending_payload[$];

  stream_byte_t script[$];
  dir_row_t     row_now = '0;
  bit           row_armed = 1'b0;
  bit           steady_src = 1'b0;
  bit           steady_sink = 1'b0;

  int mismatches = 0;
  int bytes_fed = 0;
  int payload_checked = 0;
  int setting_writes = 0;

  function automatic void flag(input string msg);
    if (mismatches < MAX_PRINTS) $display("%s", msg);
    mismatches++;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void clear_parser();
    held_q.delete();
    zrun = 0;
    in_unit = 1'b0;
    unit_type = '0;
    unit_dropped = 1'b0;
    want_first = 1'b1;
  endfunction

  function automatic void start_unit();
    in_unit = 1'b1;
    held_q.delete();
    zrun = 0;
    want_first = 1'b1;
    unit_dropped = 1'b0;
  endfunction

  function automatic void emit_payload(input logic [7:0] b, input bit last);
    payload_t p;
    if (!unit_dropped && released_now < HOLD_DEPTH + 1) begin
      p.data = b;
      p.ntype = unit_type;
      p.first = want_first;
      p.last = last;
      pending_payload.push_back(p);
      released_now++;
    end
    want_first = 1'b0;
  endfunction

  function automatic void release_oldest();
    if (held_q.size() == 0) return;
    emit_payload(held_q.pop_front(), 1'b0);
  endfunction

  // Advances the parser by one stream byte and queues the payload it releases.
  function automatic void split_byte(input logic [7:0] b, input logic eos);
    int used;
    int rest;
    released_now = 0;
    if (!in_unit) begin
      if (b == BYTE_ZERO) begin
        if (zrun < 3) zrun++;
      end else if (b == BYTE_ONE && zrun >= 2) begin
        start_unit();
      end else begin
        zrun = 0;
      end
    end else if (b == BYTE_ONE && zrun >= 2) begin
      // The start code claims two or three zeros; anything held before them
      // closes the current unit.
      used = (zrun >= 3) ? 3 : 2;
      rest = (held_q.size() > used) ? held_q.size() - used : 0;
      while (rest > 1) begin
        release_oldest();
        rest--;
      end
      if (rest == 1) emit_payload(held_q[0], 1'b1);
      start_unit();
    end else begin
      if (want_first && held_q.size() == 0) begin
        unit_type = b[4:0];
        unit_dropped = drop_aud && unit_type == TYPE_DELIM;
      end
      if (b == BYTE_ZERO) begin
        if (zrun < 3) zrun++;
        if (held_q.size() >= HOLD_DEPTH) release_oldest();
      end else begin
        while (held_q.size() > 0) release_oldest();
        zrun = 0;
      end
      if (held_q.size() < HOLD_DEPTH) held_q.push_back(b);
    end
    if (eos) begin
      if (in_unit) begin
        while (held_q.size() > 1) release_oldest();
        if (held_q.size() == 1) emit_payload(held_q[0], 1'b1);
      end
      clear_parser();
    end
  endfunction

  function automatic void queue_byte(input logic [7:0] d);
    script.push_back({d, 1'b0});
  endfunction

  function automatic logic [7:0] random_payload();
    case ($urandom_range(0, 9))
      0, 1, 2: return BYTE_ZERO;
      3:       return BYTE_ONE;
      4:       return EMU_PREVENT;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly well-formed units with random content, with some junk and broken
  // start codes mixed in.
  function automatic void build_stream(input int budget);
    int pick;
    int zeros;
    logic [4:0] t;
    stream_byte_t tail;
    while (script.size() < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
      end else if (pick < 16) begin
        queue_byte(BYTE_ZERO);
        if (pick >= 13) queue_byte(BYTE_ZERO);
        queue_byte(pick < 13 ? BYTE_ONE : EMU_PREVENT);
      end else begin
        zeros = (pick < 55) ? 2 : (pick < 90) ? 3 : $urandom_range(4, 6);
        repeat (zeros) queue_byte(BYTE_ZERO);
        queue_byte(BYTE_ONE);
        if ($urandom_range(0, 19) != 0) begin
          case ($urandom_range(0, 7))
            0:       t = TYPE_SLICE;
            1:       t = TYPE_IDR;
            2:       t = TYPE_SEI;
            3:       t = TYPE_SPS;
            4:       t = TYPE_PPS;
            5, 6:    t = TYPE_DELIM;
            default: t = 5'($urandom);
          endcase
          queue_byte({3'($urandom), t});
          repeat ($urandom_range(0, 8)) queue_byte(random_payload());
        end
      end
      if ($urandom_range(0, 11) == 0) begin
        tail = script.pop_back();
        tail.eos = 1'b1;
        script.push_back(tail);
      end
    end
  endfunction

  // Called right after a rising edge; returns at the edge of the transfer.
  task automatic push_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = steady_src ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_end_of_stream <= eos;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic settle();
    while (pending_payload.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Result side back-pressure.
  always @(posedge clk) begin
    int k;
    int sink_left;
    if (sink_left > 0) begin
      sink_left--;
    end else begin
      k = steady_sink ? 0 : idle_len();
      if (out_ready && k > 0) begin
        out_ready <= 1'b0;
        sink_left = k - 1;
      end else begin
        out_ready <= 1'b1;
        sink_left = $urandom_range(0, 10);
      end
    end
  end

  always @(posedge clk) begin
    payload_t got;
    payload_t exp_p;
    if (rst_n) begin
      // Results are checked before this edge's input is predicted, so a
      // result can never match an expectation created in the same cycle.
      if (out_valid && out_ready) begin
        got = {out_byte, out_nal_type, out_first_of_nal, out_last_of_nal};
        if (pending_payload.size() == 0) begin
          flag($sformatf("%0t: unexpected payload byte %h type %0d first %0b last %0b",
                         $time, got.data, got.ntype, got.first, got.last));
        end else begin
          exp_p = pending_payload.pop_front();
          payload_checked++;
          if (got !== exp_p)
            flag($sformatf({"%0t: expected byte %h type %0d first %0b last %0b, ",
                            "got byte %h type %0d first %0b last %0b"}, $time,
                           exp_p.data, exp_p.ntype, exp_p.first, exp_p.last,
                           got.data, got.ntype, got.first, got.last));
        end
      end
      if (in_valid && in_ready) begin
        split_byte(in_byte, in_end_of_stream);
        bytes_fed++;
        if (row_armed) begin
          if (released_now != row_now.cnt)
            flag($sformatf("%0t: byte %h should release %0d payload bytes, predicted %0d",
                           $time, row_now.data, row_now.cnt, released_now));
          else if (row_now.chk &&
                   pending_payload[pending_payload.size() - released_now] !== row_now.want)
            flag($sformatf("%0t: table expects payload %h, predicted %h", $time,
                           row_now.want,
                           pending_payload[pending_payload.size() - released_now]));
        end
      end
      if (cfg_we) drop_aud = cfg_wdata;
    end
  end

  initial begin
    stream_byte_t sb;
    logic v;
    clear_parser();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The table runs with the reset setting, so delimiter units are dropped.
    for (int i = 0; i < DIR_ROWS; i++) begin
      row_now <= DIRECTED[i];
      row_armed <= 1'b1;
      push_byte(DIRECTED[i].data, DIRECTED[i].eos);
    end
    row_armed <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      in_valid <= 1'b0;
      settle();
      v = (ph < 4) ? ph[0] == 1'b0 ? 1'b0 : 1'b1 : 1'($urandom);
      cfg_we <= 1'b1;
      cfg_wdata <= v;
      @(posedge clk);
      cfg_we <= 1'b0;
      setting_writes++;
      steady_src = (ph == 2);
      steady_sink <= (ph == 3);
      build_stream(PHASE_LEN);
      while (script.size() > 0) begin
        sb = script.pop_front();
        push_byte(sb.data, sb.eos);
      end
    end
    in_valid <= 1'b0;
    settle();

    $display("Fed %0d stream bytes (%0d from the table) over %0d phases, %0d setting writes.",
             bytes_fed, DIR_ROWS, PHASES, setting_writes);
    $display("Compared %0d payload bytes, %0d mismatches.", payload_checked, mismatches);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
hdl/annexb_pkg.sv
hdl/annexb_front.sv
hdl/annexb_queue.sv
hdl/annexb_back.sv
hdl/annexb_nal_unit_splitter_unit.sv
tb/annexb_nal_unit_splitter_unit_tb.sv
